@@ rtl/kea_pkg.sv @@
// Package for the key edge and auto-repeat block.
// Holds the payload structs, configuration register codes and reset values.
// No dependencies.
package kea_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_DELAY    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;

    localparam logic [15:0] REPEAT_DELAY_RESET    = 16'd30;
    localparam logic [7:0]  REPEAT_INTERVAL_RESET = 8'd4;

    typedef struct packed {
        logic [7:0] key_index;
        logic [7:0] key_value;
    } kea_in_t;

    typedef struct packed {
        logic [7:0] key_echo;
        logic [7:0] press_edge;
        logic [7:0] release_edge;
        logic [7:0] repeat_pulse;
    } kea_out_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } kea_rem_stat_t;

endpackage

@@ rtl/kea_rem.sv @@
// Iterative remainder unit: one restoring shift-subtract step per cycle.
// Reports whether the dividend is a multiple of an 8-bit nonzero divisor.
// Depends on kea_pkg.
module kea_rem #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [COUNT_WIDTH-1:0]    dividend,
    input  logic [7:0]                divisor,
    output kea_pkg::kea_rem_stat_t    stat
);
    import kea_pkg::*;

    localparam int CNT_W = $clog2(COUNT_WIDTH + 1);

    logic [COUNT_WIDTH-1:0] quo_reg, quo_next;
    logic [7:0]             rem_reg, rem_next;
    logic [7:0]             div_reg, div_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [8:0]             trial;

    assign trial = {rem_reg, quo_reg[COUNT_WIDTH-1]};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = 8'd0;
            div_next  = divisor;
            cnt_next  = CNT_W'(COUNT_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = quo_reg << 1;
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = 8'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[7:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == 8'd0);

endmodule

@@ rtl/kea_state_mem.sv @@
// Per-key state memory with one write port and one registered read port.
// After reset a sweep writes zero to every entry, one per cycle.
// No package dependency.
module kea_state_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic              clearing
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              clr_busy_reg, clr_busy_next;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    assign clearing = clr_busy_reg;

endmodule

@@ rtl/key_edge_and_autorepeat_top.sv @@
// Top level of the key edge and auto-repeat block: sequencer, configuration
// registers and output register. Depends on kea_pkg, kea_state_mem and kea_rem.
//
// Each transfer carries one key's new state byte for a polling frame and yields
// one result with the press edge, release edge and repeat byte for that key.
// The block takes one key at a time. Between one input transfer and the next,
// a key held past the repeat delay passes the read, calc, divide and finish
// steps, the divide step paced by the shift-subtract remainder unit that runs
// one bit per cycle; other keys in range skip the divide step, and a key at or
// above KEY_COUNT skips calc too. A result that waits on the output holds the
// block in the finish step. After reset the state memory clears its
// min(KEY_COUNT, 256) entries, during which no input is taken; configuration
// writes are taken at any time and must only be made while the block is idle.
module key_edge_and_autorepeat_top #(
    parameter int KEY_COUNT   = 256,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  kea_pkg::kea_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output kea_pkg::kea_out_t                  out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [kea_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [kea_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import kea_pkg::*;

    localparam int DEPTH  = (KEY_COUNT < 256) ? KEY_COUNT : 256;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 16 + COUNT_WIDTH;
    localparam int CMP_W  = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_CALC   = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [15:0]            delay_reg;
    logic [7:0]             interval_reg;
    logic [7:0]             key_reg;
    logic [7:0]             now_reg;
    logic                   in_range_reg;
    logic [7:0]             press_reg, release_reg;
    logic [COUNT_WIDTH-1:0] cnt_new_reg;
    logic [7:0]             rep_new_reg;
    logic                   out_valid_reg, out_valid_next;
    kea_out_t               out_data_reg;

    logic                   in_accept;
    logic                   mem_rd_en;
    logic [DATA_W-1:0]      mem_rd_data;
    logic                   mem_wr_en;
    logic [DATA_W-1:0]      mem_wr_data;
    logic                   mem_clearing;
    logic                   out_free;

    logic [7:0]             old_val;
    logic [COUNT_WIDTH-1:0] old_cnt;
    logic [7:0]             old_rep;
    logic [7:0]             diff;
    logic [COUNT_WIDTH-1:0] cnt_calc;
    logic [7:0]             rep_calc;
    logic                   need_rem;
    logic [7:0]             divisor;
    kea_rem_stat_t          rem_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= REPEAT_DELAY_RESET;
            interval_reg <= REPEAT_INTERVAL_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_REPEAT_DELAY:    delay_reg    <= cfg_data;
                REG_REPEAT_INTERVAL: interval_reg <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE) && !mem_clearing;
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign old_val = mem_rd_data[DATA_W-1 -: 8];
    assign old_cnt = mem_rd_data[COUNT_WIDTH+7:8];
    assign old_rep = mem_rd_data[7:0];
    assign diff    = old_val ^ now_reg;
    assign divisor = (interval_reg == 8'd0) ? 8'd1 : interval_reg;

    always_comb
    begin
        cnt_calc = old_cnt;
        rep_calc = old_rep;
        need_rem = 1'b0;
        if (now_reg != 8'd0)
        begin
            if (old_cnt != {COUNT_WIDTH{1'b1}})
            begin
                cnt_calc = old_cnt + 1'b1;
            end
            need_rem = CMP_W'(cnt_calc) > CMP_W'(delay_reg);
        end
        else if ((old_val & diff) != 8'd0)
        begin
            cnt_calc = '0;
            rep_calc = 8'd0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_rd_en      = 1'b0;
        mem_wr_en      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                mem_rd_en  = in_range_reg;
                state_next = in_range_reg ? ST_CALC : ST_FINISH;
            end
            ST_CALC:
            begin
                state_next = need_rem ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                if (rem_stat.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    mem_wr_en      = in_range_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            key_reg      <= in_data.key_index;
            now_reg      <= in_data.key_value;
            in_range_reg <= 32'(in_data.key_index) < KEY_COUNT;
            press_reg    <= 8'd0;
            release_reg  <= 8'd0;
            rep_new_reg  <= 8'd0;
        end
        if (state_reg == ST_CALC)
        begin
            press_reg   <= now_reg & diff;
            release_reg <= old_val & diff;
            cnt_new_reg <= cnt_calc;
            rep_new_reg <= rep_calc;
        end
        if ((state_reg == ST_DIV) && rem_stat.done)
        begin
            rep_new_reg <= rem_stat.rem_zero ? now_reg : 8'd0;
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_data_reg.key_echo     <= key_reg;
            out_data_reg.press_edge   <= press_reg;
            out_data_reg.release_edge <= release_reg;
            out_data_reg.repeat_pulse <= rep_new_reg;
        end
    end

    assign mem_wr_data = {now_reg, cnt_new_reg, rep_new_reg};

    kea_state_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_state_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (mem_rd_en),
        .rd_addr  (key_reg[ADDR_W-1:0]),
        .rd_data  (mem_rd_data),
        .wr_en    (mem_wr_en),
        .wr_addr  (key_reg[ADDR_W-1:0]),
        .wr_data  (mem_wr_data),
        .clearing (mem_clearing)
    );

    kea_rem #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    ((state_reg == ST_CALC) && need_rem),
        .dividend (cnt_calc),
        .divisor  (divisor),
        .stat     (rem_stat)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The sequencer takes no new item while a transfer is being processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ready)
        else $error("input taken while an item is in progress");

    // The memory sweep after reset keeps the input closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_clearing |-> !in_ready)
        else $error("input ready during memory clear");

    // The remainder unit finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        rem_stat.done |-> (state_reg == ST_DIV))
        else $error("remainder result outside the divide step");

    // A new result only appears when the sequencer completes an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

endmodule

@@ tb/key_edge_and_autorepeat_top_tb.sv @@
// Self-checking testbench for key_edge_and_autorepeat_top: directed key frames, a long
// hold of one key, then random typing under several handshake stall patterns.
// Depends on kea_pkg and the RTL of key_edge_and_autorepeat_top only.
`timescale 1ns / 1ps

module key_edge_and_autorepeat_top_tb;

    import kea_pkg::*;

    localparam int KEY_COUNT   = 256;
    localparam int COUNT_WIDTH = 16;
    localparam int SETTLE_CYCLES = COUNT_WIDTH + 24;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam logic [COUNT_WIDTH-1:0] HOLD_CEILING = '1;

    class typematic_tracker;
        bit [7:0]             last_byte [KEY_COUNT];
        bit [COUNT_WIDTH-1:0] hold_frames [KEY_COUNT];
        bit [7:0]             repeat_val [KEY_COUNT];
        bit [15:0]            delay_frames;
        bit [7:0]             interval_frames;
        kea_out_t             expected_reports [$];
        int                   failures;

        function new();
            foreach (last_byte[k])
            begin
                last_byte[k]   = '0;
                hold_frames[k] = '0;
                repeat_val[k]  = '0;
            end
            delay_frames    = REPEAT_DELAY_RESET;
            interval_frames = REPEAT_INTERVAL_RESET;
            failures        = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_REPEAT_DELAY)
                delay_frames = data;
            else if (idx == REG_REPEAT_INTERVAL)
                interval_frames = data[7:0];
        endfunction

        function void note_sample(kea_in_t sample);
            bit [7:0] k;
            bit [7:0] now_byte;
            bit [7:0] old_byte;
            bit [7:0] diff;
            bit [7:0] step;
            kea_out_t report;
            k        = sample.key_index;
            now_byte = sample.key_value;
            old_byte = last_byte[k];
            diff     = old_byte ^ now_byte;
            report.key_echo     = k;
            report.press_edge   = now_byte & diff;
            report.release_edge = old_byte & diff;
            if (now_byte != 0)
            begin
                if (hold_frames[k] != HOLD_CEILING)
                    hold_frames[k]++;
                if (hold_frames[k] > delay_frames)
                begin
                    step = (interval_frames == 0) ? 8'd1 : interval_frames;
                    repeat_val[k] = (hold_frames[k] % step == 0) ? now_byte : 8'd0;
                end
            end
            else if (report.release_edge != 0)
            begin
                hold_frames[k] = '0;
                repeat_val[k]  = '0;
            end
            last_byte[k]        = now_byte;
            report.repeat_pulse = repeat_val[k];
            expected_reports.push_back(report);
        endfunction

        function void check_report(kea_out_t got);
            kea_out_t want;
            if (expected_reports.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with none expected: key %0d press %h release %h rep %h",
                             $time, got.key_echo, got.press_edge, got.release_edge,
                             got.repeat_pulse);
                return;
            end
            want = expected_reports.pop_front();
            if (got.key_echo !== want.key_echo || got.press_edge !== want.press_edge ||
                got.release_edge !== want.release_edge || got.repeat_pulse !== want.repeat_pulse)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: expected %0d %h %h %h, got %0d %h %h %h",
                             $time, want.key_echo, want.press_edge, want.release_edge,
                             want.repeat_pulse, got.key_echo, got.press_edge,
                             got.release_edge, got.repeat_pulse);
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void final_check();
            if (expected_reports.size() != 0)
            begin
                failures++;
                $display("%0d expected results never arrived", expected_reports.size());
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    kea_in_t                in_data;
    logic                   out_valid;
    logic                   out_ready;
    kea_out_t               out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int send_idle_pct;
    int stall_pct;

    typematic_tracker tracker = new();

    key_edge_and_autorepeat_top #(
        .KEY_COUNT   (KEY_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.check_report(out_data);
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_reg(idx, data);
    endtask

    task automatic set_timing(logic [15:0] delay_val, logic [15:0] interval_data);
        write_reg(REG_REPEAT_DELAY, delay_val);
        write_reg(REG_REPEAT_INTERVAL, interval_data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(logic [7:0] key, logic [7:0] value);
        kea_in_t sample;
        sample.key_index = key;
        sample.key_value = value;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= sample;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_sample(sample);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic finish_phase();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Several keys are typed at once: each press is held for a random number of
    // frames, sometimes with a changing byte, then released. Stray frames mix in.
    task automatic run_typing(int n_items);
        int       hold_left [6];
        bit [7:0] held_val [6];
        bit [7:0] pool [6];
        int       i;
        int       slot;
        foreach (pool[s])
        begin
            pool[s]      = 8'($urandom_range(255));
            hold_left[s] = 0;
            held_val[s]  = '0;
        end
        for (i = 0; i < n_items; i++)
        begin
            if (i == n_items / 2)
                wait_drained();
            if ($urandom_range(99) < 15)
                send_sample(8'($urandom_range(255)), 8'($urandom_range(255)));
            else
            begin
                slot = $urandom_range(5);
                if (hold_left[slot] > 0)
                begin
                    if ($urandom_range(3) == 0)
                        held_val[slot] = 8'($urandom_range(255, 1));
                    hold_left[slot]--;
                    send_sample(pool[slot], held_val[slot]);
                end
                else if (held_val[slot] != 0)
                begin
                    held_val[slot] = '0;
                    send_sample(pool[slot], 8'd0);
                end
                else
                begin
                    hold_left[slot] = $urandom_range(60);
                    held_val[slot]  = 8'($urandom_range(255, 1));
                    send_sample(pool[slot], held_val[slot]);
                end
            end
        end
        finish_phase();
    endtask

    initial
    begin
        logic [15:0] delays [8];
        logic [15:0] intervals [8];
        int          p;
        int          i;
        delays    = '{16'd30, 16'd0, 16'd3, 16'hFFFF, 16'd12, 16'd1, 16'd5, 16'd2};
        intervals = '{16'h0004, 16'h0001, 16'h00FF, 16'h0003,
                      16'h0000, 16'hFF02, 16'h0007, 16'h0005};
        send_idle_pct = 0;
        stall_pct     = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_REPEAT_DELAY;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset timing: idle key, extreme keys and bytes, simultaneous press and
        // release on a held key, then full releases.
        send_sample(8'd0, 8'h00);
        send_sample(8'd255, 8'hFF);
        send_sample(8'd255, 8'hFF);
        send_sample(8'd0, 8'h01);
        send_sample(8'd0, 8'h80);
        send_sample(8'd0, 8'h00);
        send_sample(8'd255, 8'h00);
        send_sample(8'd128, 8'h0F);
        send_sample(8'd128, 8'hF0);
        send_sample(8'd128, 8'h00);
        finish_phase();

        // A zero interval repeats on every frame once past a zero delay.
        set_timing(16'd0, 16'd0);
        repeat (3) send_sample(8'd7, 8'h5A);
        finish_phase();

        // Registers that do not exist must change nothing; upper interval bits
        // are dropped. Inside the new delay the repeat byte keeps its value.
        write_reg(REG_SPARE_3, 16'hFFFF);
        write_reg(REG_SPARE_2, 16'h0000);
        set_timing(16'd10, 16'h12FF);
        send_sample(8'd7, 8'h5A);
        send_sample(8'd7, 8'hA5);
        send_sample(8'd7, 8'h00);
        send_sample(8'd7, 8'h33);
        send_sample(8'd7, 8'h33);
        finish_phase();

        set_timing(16'd1, 16'd2);
        repeat (4) send_sample(8'd9, 8'hC3);
        send_sample(8'd9, 8'h00);
        finish_phase();

        // Hold one key for a long stretch, then keep holding under another
        // interval and under a delay that the count has not yet reached.
        set_timing(16'd40, 16'd1);
        for (i = 0; i < 100; i++)
            send_sample(8'd200, 8'($urandom_range(255, 1)));
        finish_phase();
        set_timing(16'd90, 16'd3);
        send_sample(8'd200, 8'h11);
        send_sample(8'd200, 8'h22);
        finish_phase();
        set_timing(16'd200, 16'd5);
        send_sample(8'd200, 8'h44);
        send_sample(8'd200, 8'h44);
        send_sample(8'd200, 8'h00);
        finish_phase();

        for (p = 0; p < 8; p++)
        begin
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 55;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 55;
                end
                default:
                begin
                    send_idle_pct = 22;
                    stall_pct     = 22;
                end
            endcase
            set_timing(delays[p], intervals[p]);
            run_typing(220);
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        finish_phase();
        tracker.final_check();
        if (tracker.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/kea_pkg.sv
rtl/kea_rem.sv
rtl/kea_state_mem.sv
rtl/key_edge_and_autorepeat_top.sv
tb/key_edge_and_autorepeat_top_tb.sv
